@@ rtl/fit_policy_partition_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the partition allocator
// Concurrent check wrappers sampled on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_PARTITION_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_PARTITION_ALLOCATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FPPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// antecedent implies consequent in the next cycle
`define FPPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

// expression holds at every edge
`define FPPA_ASSERT_ALW(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");

`endif

@@ rtl/fppa_pkg.sv @@
// ----------------------------------------------------------------------------
// fppa_pkg
// Shared types and constants of the partition allocator.
// ----------------------------------------------------------------------------
package fppa_pkg;

    localparam int NUM_PARTITIONS = 16;
    localparam int SIZE_WIDTH     = 16;
    localparam int IDX_W          = $clog2(NUM_PARTITIONS);
    localparam int CNT_W          = $clog2(NUM_PARTITIONS + 1);

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_PARTS_USED = 1'b1;

    localparam logic [4:0] PARTS_USED_RESET = 5'd16;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_policy_t;

    typedef struct packed {
        logic        action;
        logic [3:0]  partition_index;
        logic [15:0] size_value;
    } in_word_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_index;
        logic [15:0] remaining_size;
    } out_word_t;

    // request context seen by every cell during a scan
    typedef struct packed {
        fit_policy_t           policy;
        logic [SIZE_WIDTH-1:0] req_size;
        logic [IDX_W-1:0]      start;
        logic [CNT_W-1:0]      used_n;
    } fppa_req_t;

    // running search result handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [IDX_W-1:0]      pick_idx;
        logic [SIZE_WIDTH-1:0] pick_val;
        logic                  hi_found;
        logic [IDX_W-1:0]      hi_idx;
        logic [SIZE_WIDTH-1:0] hi_val;
        logic                  lo_found;
        logic [IDX_W-1:0]      lo_idx;
        logic [SIZE_WIDTH-1:0] lo_val;
    } fppa_carry_t;

endpackage

@@ rtl/fppa_cell.sv @@
// ----------------------------------------------------------------------------
// fppa_cell
// One partition entry plus one stage of the search chain.
// ----------------------------------------------------------------------------
module fppa_cell
    import fppa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      cell_idx,
    input  fppa_req_t             req,
    input  fppa_carry_t           carry_in,
    input  logic                  wr_en,
    input  logic [SIZE_WIDTH-1:0] wr_data,
    output fppa_carry_t           carry_out
);

    logic [SIZE_WIDTH-1:0] entry_reg;
    fppa_carry_t           carry_reg;
    fppa_carry_t           carry_next;
    logic                  adequate;
    logic                  upper;

    always_comb
    begin
        adequate   = (CNT_W'(cell_idx) < req.used_n) && (entry_reg >= req.req_size);
        upper      = cell_idx >= req.start;
        carry_next = carry_in;
        if (adequate)
        begin
            case (req.policy)
                FIT_FIRST:
                begin
                    if (!carry_in.found)
                    begin
                        carry_next.found    = 1'b1;
                        carry_next.pick_idx = cell_idx;
                        carry_next.pick_val = entry_reg;
                    end
                end
                FIT_BEST:
                begin
                    if (!carry_in.found || entry_reg < carry_in.pick_val)
                    begin
                        carry_next.found    = 1'b1;
                        carry_next.pick_idx = cell_idx;
                        carry_next.pick_val = entry_reg;
                    end
                end
                FIT_WORST:
                begin
                    if (!carry_in.found || entry_reg > carry_in.pick_val)
                    begin
                        carry_next.found    = 1'b1;
                        carry_next.pick_idx = cell_idx;
                        carry_next.pick_val = entry_reg;
                    end
                end
                default:
                begin
                    // next fit: first hit at or after start, else first hit below it
                    if (upper && !carry_in.hi_found)
                    begin
                        carry_next.hi_found = 1'b1;
                        carry_next.hi_idx   = cell_idx;
                        carry_next.hi_val   = entry_reg;
                    end
                    if (!upper && !carry_in.lo_found)
                    begin
                        carry_next.lo_found = 1'b1;
                        carry_next.lo_idx   = cell_idx;
                        carry_next.lo_val   = entry_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg       <= '0;
            carry_reg       <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_reg <= wr_data;
            end
            carry_reg       <= carry_next;
        end
    end

    assign carry_out = carry_reg;

endmodule

@@ rtl/fit_policy_partition_allocator.sv @@
// ----------------------------------------------------------------------------
// fit_policy_partition_allocator
// Partition allocator with first, next, best and worst fit policies.
// ----------------------------------------------------------------------------
// A load word goes from acceptance straight to S_FINISH; a request word
// passes the launch register and walks the chain of partition cells one
// cell per cycle, S_SCAN latches the pick, then S_FINISH writes the chosen
// entry back and loads the result register, waiting while a previous result
// is held by out_stall. One word is in work at a time; a new word is taken
// while the previous result still waits on out_stall. All entries reset to
// zero at once, no clearing pass.
module fit_policy_partition_allocator
    import fppa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "fit_policy_partition_allocator_defines.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                state_reg;
    fit_policy_t           policy_reg;
    logic [4:0]            parts_used_reg;
    logic [IDX_W-1:0]      nf_start_reg;
    logic                  launch_reg;
    logic [SIZE_WIDTH-1:0] size_reg;
    logic                  res_granted_reg;
    logic [3:0]            res_idx_reg;
    logic [15:0]           res_rem_reg;
    logic                  res_wr_reg;
    logic [IDX_W-1:0]      res_wr_idx_reg;
    logic [SIZE_WIDTH-1:0] res_wr_data_reg;
    logic                  res_load_reg;
    logic                  out_valid_reg;
    out_word_t             out_word_reg;

    logic                  in_fire;
    logic                  finish_fire;
    logic                  cfg_write;
    logic [CNT_W-1:0]      used_n;
    logic [SIZE_WIDTH-1:0] in_size;
    fppa_req_t             req;
    fppa_carry_t           launch_carry;
    fppa_carry_t           carry [NUM_PARTITIONS];
    fppa_carry_t           last;
    logic [NUM_PARTITIONS-1:0] cell_wr;
    logic [NUM_PARTITIONS-1:0] chain_valid;
    logic                  sel_found;
    logic [IDX_W-1:0]      sel_idx;
    logic [SIZE_WIDTH-1:0] sel_val;
    logic [SIZE_WIDTH-1:0] sel_rem;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_fire     = in_valid && !in_stall;
    assign finish_fire = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
    assign cfg_write   = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_word    = out_word_reg;
    assign in_size     = SIZE_WIDTH'(in_word.size_value);

    always_comb
    begin
        case (paddr[2])
            REG_FIT_POLICY: prdata = {30'd0, policy_reg};
            default:        prdata = {27'd0, parts_used_reg};
        endcase
    end

    always_comb
    begin
        if (32'(parts_used_reg) > NUM_PARTITIONS)
        begin
            used_n = CNT_W'(NUM_PARTITIONS);
        end
        else
        begin
            used_n = CNT_W'(parts_used_reg);
        end
    end

    always_comb
    begin
        req.policy   = policy_reg;
        req.req_size = size_reg;
        req.used_n   = used_n;
        req.start    = (CNT_W'(nf_start_reg) < used_n) ? nf_start_reg : '0;
        launch_carry       = '0;
        launch_carry.valid = launch_reg;
    end

    genvar k;
    generate
        for (k = 0; k < NUM_PARTITIONS; k++)
        begin : g_cell
            fppa_carry_t cin;
            if (k == 0)
            begin : g_head
                assign cin = launch_carry;
            end
            else
            begin : g_link
                assign cin = carry[k-1];
            end
            assign cell_wr[k]     = finish_fire && res_wr_reg && (res_wr_idx_reg == IDX_W'(k));
            assign chain_valid[k] = carry[k].valid;
            fppa_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (IDX_W'(k)),
                .req       (req),
                .carry_in  (cin),
                .wr_en     (cell_wr[k]),
                .wr_data   (res_wr_data_reg),
                .carry_out (carry[k])
            );
        end
    endgenerate

    assign last = carry[NUM_PARTITIONS-1];

    always_comb
    begin
        if (policy_reg == FIT_NEXT)
        begin
            sel_found = last.hi_found || last.lo_found;
            sel_idx   = last.hi_found ? last.hi_idx : last.lo_idx;
            sel_val   = last.hi_found ? last.hi_val : last.lo_val;
        end
        else
        begin
            sel_found = last.found;
            sel_idx   = last.pick_idx;
            sel_val   = last.pick_val;
        end
        sel_rem = sel_val - size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            policy_reg      <= FIT_FIRST;
            parts_used_reg  <= PARTS_USED_RESET;
            nf_start_reg    <= '0;
            launch_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            res_wr_reg      <= 1'b0;
            res_load_reg    <= 1'b0;
        end
        else
        begin
            launch_reg <= in_fire && (in_word.action == ACT_REQUEST);
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_FIT_POLICY: policy_reg     <= fit_policy_t'(pwdata[1:0]);
                    default:        parts_used_reg <= pwdata[4:0];
                endcase
            end
            if (out_valid_reg && !out_stall && !finish_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        size_reg <= in_size;
                        if (in_word.action == ACT_LOAD)
                        begin
                            res_load_reg    <= 1'b1;
                            res_granted_reg <= 1'b0;
                            res_idx_reg     <= in_word.partition_index;
                            res_wr_idx_reg  <= IDX_W'(in_word.partition_index);
                            res_wr_data_reg <= in_size;
                            if (32'(in_word.partition_index) < NUM_PARTITIONS)
                            begin
                                res_wr_reg  <= 1'b1;
                                res_rem_reg <= 16'(in_size);
                            end
                            else
                            begin
                                res_wr_reg  <= 1'b0;
                                res_rem_reg <= '0;
                            end
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            res_load_reg <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (last.valid)
                    begin
                        res_granted_reg <= sel_found;
                        res_wr_reg      <= sel_found;
                        res_idx_reg     <= sel_found ? 4'(sel_idx) : 4'd0;
                        res_rem_reg     <= sel_found ? 16'(sel_rem) : 16'd0;
                        res_wr_idx_reg  <= sel_idx;
                        res_wr_data_reg <= sel_rem;
                        state_reg       <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (finish_fire)
                    begin
                        out_valid_reg               <= 1'b1;
                        out_word_reg.granted        <= res_granted_reg;
                        out_word_reg.chosen_index   <= res_idx_reg;
                        out_word_reg.remaining_size <= res_rem_reg;
                        if (res_load_reg)
                        begin
                            nf_start_reg <= '0;
                        end
                        else if (res_granted_reg && policy_reg == FIT_NEXT)
                        begin
                            nf_start_reg <= res_wr_idx_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // only one search word is ever in the chain
    `FPPA_ASSERT_ALW(a_one_word_in_chain, $onehot0({chain_valid, launch_reg}))
    // the search word only leaves the chain while scanning
    `FPPA_ASSERT_IMP(a_exit_in_scan, last.valid, state_reg == S_SCAN)
    // at most one partition is updated per cycle
    `FPPA_ASSERT_ALW(a_single_write, $onehot0(cell_wr))
    // finishing a word always presents a result
    `FPPA_ASSERT_NXT(a_finish_result, finish_fire, out_valid_reg && state_reg == S_IDLE)

endmodule
